// ===== sv/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg: shared types, constants and round functions for AES-128 encrypt
// S-box table, GF doubling, round constant lookup and one-round helpers.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NumRounds = 10;

    typedef logic [127:0] blk_t;
    typedef logic [7:0]   byte_t;

    typedef struct packed {
        logic [63:0] plain_hi;
        logic [63:0] plain_lo;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
    } in_word_t;

    typedef struct packed {
        logic [63:0] cipher_hi;
        logic [63:0] cipher_lo;
    } out_word_t;

    localparam byte_t Sbox [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t Rcon [NumRounds] = '{8'h01,8'h02,8'h04,8'h08,8'h10,
                                           8'h20,8'h40,8'h80,8'h1b,8'h36};

    // byte i of a block sits at bits 127-8i
    function automatic byte_t get_byte(input blk_t b, input int i);
        return b[127-8*i -: 8];
    endfunction

    function automatic byte_t gf_dbl(input byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // next round key from the previous one
    function automatic blk_t next_key(input blk_t p, input byte_t rc);
        byte_t t [4];
        blk_t  q;
        t[0] = Sbox[get_byte(p, 13)] ^ rc;
        t[1] = Sbox[get_byte(p, 14)];
        t[2] = Sbox[get_byte(p, 15)];
        t[3] = Sbox[get_byte(p, 12)];
        for (int j = 0; j < 16; j++)
        begin
            t[j%4] = t[j%4] ^ get_byte(p, j);
            q[127-8*j -: 8] = t[j%4];
        end
        return q;
    endfunction

    function automatic blk_t sub_shift(input blk_t s);
        blk_t t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(4*c+r) -: 8] = Sbox[get_byte(s, 4*((c+r)%4)+r)];
        return t;
    endfunction

    function automatic blk_t mix_columns(input blk_t s);
        blk_t  t;
        byte_t a [4];
        byte_t all;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
                a[r] = get_byte(s, 4*c+r);
            all = a[0] ^ a[1] ^ a[2] ^ a[3];
            for (int r = 0; r < 4; r++)
                t[127-8*(4*c+r) -: 8] = a[r] ^ all ^ gf_dbl(a[r] ^ a[(r+1)%4]);
        end
        return t;
    endfunction

endpackage

// ===== sv/aes_stream_if.sv =====
// ----------------------------------------------------------------------------
// aes_stream_if: valid/ready channel carrying one word of type T
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface aes_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/aes_round_cell.sv =====
// ----------------------------------------------------------------------------
// aes_round_cell: one round of the cipher chain
// Takes state and previous round key, produces next state and round key.
// The last cell of the chain skips MixColumns.
// ----------------------------------------------------------------------------
module aes_round_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           last_round,
    input  aes_pkg::byte_t rcon,
    input  logic           valid_in,
    input  aes_pkg::blk_t  state_in,
    input  aes_pkg::blk_t  key_in,
    output logic           valid_out,
    output aes_pkg::blk_t  state_out,
    output aes_pkg::blk_t  key_out
);
    import aes_pkg::*;

    logic valid_reg;
    blk_t state_reg;
    blk_t key_reg;
    blk_t key_next;
    blk_t state_next;
    blk_t shifted;

    always_comb
    begin
        key_next   = next_key(key_in, rcon);
        shifted    = sub_shift(state_in);
        state_next = (last_round ? shifted : mix_columns(shifted)) ^ key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;
endmodule

// ===== sv/aes128_block_encrypt_top.sv =====
// ----------------------------------------------------------------------------
// aes128_block_encrypt_top: AES-128 block encryption, fully unrolled
// Eleven-stage chain: initial AddRoundKey stage and ten round cells.
// ----------------------------------------------------------------------------
//  channel   dir  word
//  in_ch     in   plain_hi, plain_lo, key_hi, key_lo
//  out_ch    out  cipher_hi, cipher_lo
//
//  One word per cycle sustained while the output is not stalled; eleven register
//  stages (key-whitening stage plus one per round cell).
//  The whole chain advances when the output stage is empty or being taken;
//  a stalled output freezes every stage, bubbles stay in place.
//  Reset clears only the valid bits of the chain.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_top (
    input  logic       clk,
    input  logic       rst_n,
    aes_stream_if.sink   in_ch,
    aes_stream_if.source out_ch
);
    import aes_pkg::*;

    logic advance;
    logic v0_reg;
    blk_t s0_reg;
    blk_t k0_reg;

    logic valid_c [NumRounds+1];
    blk_t state_c [NumRounds+1];
    blk_t key_c   [NumRounds+1];

    assign advance     = !valid_c[NumRounds] || out_ch.ready;
    assign in_ch.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (advance)
            v0_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_reg <= {in_ch.data.plain_hi, in_ch.data.plain_lo}
                    ^ {in_ch.data.key_hi, in_ch.data.key_lo};
            k0_reg <= {in_ch.data.key_hi, in_ch.data.key_lo};
        end
    end

    assign valid_c[0] = v0_reg;
    assign state_c[0] = s0_reg;
    assign key_c[0]   = k0_reg;

    for (genvar r = 0; r < NumRounds; r++)
    begin : g_round
        aes_round_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .last_round (r == NumRounds - 1),
            .rcon       (Rcon[r]),
            .valid_in   (valid_c[r]),
            .state_in   (state_c[r]),
            .key_in     (key_c[r]),
            .valid_out  (valid_c[r+1]),
            .state_out  (state_c[r+1]),
            .key_out    (key_c[r+1])
        );
    end

    assign out_ch.valid          = valid_c[NumRounds];
    assign out_ch.data.cipher_hi = state_c[NumRounds][127:64];
    assign out_ch.data.cipher_lo = state_c[NumRounds][63:0];

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("output word changed under stall");
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("chain blocked with empty output");
    a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> v0_reg)
        else $error("accepted word lost at first stage");
endmodule
